// ===== rtl/sha1bh_pkg.sv =====
package sha1bh_pkg;

  // Message length counter width (default, range 32..64)
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Block geometry
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES) + 1;
  localparam logic [FILL_W-1:0] LEN_FIELD_POS = FILL_W'(56);
  localparam int unsigned ROUNDS      = 80;
  localparam logic [6:0] LAST_ROUND   = 7'd79;

  // Padding
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;
  localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

  // Digest output
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // Initial chaining words
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef logic [4:0][31:0] chain_t;
  typedef logic [15:0][31:0] sched_t;

  // One queued request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  // Control from sequencer to compression unit
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctrl_t;

  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_FINAL,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/sha1bh_front.sv =====
module sha1bh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_has_byte,
  input  logic               in_end_of_message,
  output logic               item_valid,
  output sha1bh_pkg::item_t  item,
  input  logic               item_pop
);
  import sha1bh_pkg::*;

  item_t                 q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic                  accept;
  logic                  push;
  logic                  pop;

  // Requests with neither byte nor end are taken and dropped
  assign in_stall   = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept     = in_valid & ~in_stall;
  assign push       = accept & (in_has_byte | in_end_of_message);
  assign item_valid = (count_r != '0);
  assign pop        = item_pop & item_valid;
  assign item       = q_mem[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{data_byte: in_data_byte, has_byte: in_has_byte,
                           end_of_message: in_end_of_message};
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/sha1bh_compress.sv =====
module sha1bh_compress (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1bh_pkg::cmp_ctrl_t ctrl,
  input  logic [511:0]          block,
  output logic                  busy,
  output sha1bh_pkg::chain_t    chain
);
  import sha1bh_pkg::*;

  logic        run_r, fin_r;
  logic [6:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  sched_t      w_r;
  chain_t      h_r;
  logic [31:0] f, k, t, w_new;

  assign busy  = run_r | fin_r;
  assign chain = h_r;

  // Round function and schedule expansion
  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]}) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (rnd_r inside {[7'd20:7'd39]}) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (rnd_r inside {[7'd40:7'd59]}) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_r[0];
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      rnd_r <= '0;
    end else if (ctrl.start) begin
      run_r <= 1'b1;
      rnd_r <= '0;
    end else if (run_r) begin
      rnd_r <= rnd_r + 1'b1;
      if (rnd_r == LAST_ROUND) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end else begin
      fin_r <= 1'b0;
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= block[511-32*i -: 32];
      end
    end else if (run_r) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      w_r <= {w_new, w_r[15:1]};
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      h_r <= {IV4, IV3, IV2, IV1, IV0};
    end else if (fin_r) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

endmodule

// ===== rtl/sha1bh_back.sv =====
module sha1bh_back #(
  parameter int unsigned LENGTH_BITS = sha1bh_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  sha1bh_pkg::item_t item,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);
  import sha1bh_pkg::*;

  localparam logic [LENGTH_BITS-1:0] BYTE_BITS = LENGTH_BITS'(8);

  back_state_t             state_r, state_nxt;
  logic [511:0]            buf_r;
  logic [FILL_W-1:0]       fill_r;
  logic [LENGTH_BITS-1:0]  bit_count_r;
  logic [2:0]              len_idx_r, len_idx_nxt;
  logic [2:0]              word_cnt_r, word_cnt_nxt;
  logic                    out_valid_r;
  logic [31:0]             out_word_r;
  logic [2:0]              out_idx_r;
  logic                    out_last_r;
  logic [63:0]             len64;
  logic                    room, full, busy;
  logic                    shift_en, add_bits, clr_bits, load_out;
  logic [7:0]              shift_byte;
  cmp_ctrl_t               cmp_ctrl;
  chain_t                  chain;

  sha1bh_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cmp_ctrl),
    .block (buf_r),
    .busy  (busy),
    .chain (chain)
  );

  assign full  = fill_r[FILL_W-1];
  assign room  = ~full;
  assign len64 = 64'(bit_count_r);

  // Sequencer: absorb, pad, final compress, emit
  always_comb begin
    state_nxt      = state_r;
    len_idx_nxt    = len_idx_r;
    word_cnt_nxt   = word_cnt_r;
    item_pop       = 1'b0;
    shift_en       = 1'b0;
    shift_byte     = PAD_ZERO;
    add_bits       = 1'b0;
    clr_bits       = 1'b0;
    load_out       = 1'b0;
    cmp_ctrl.start = full & ~busy;
    cmp_ctrl.init  = 1'b0;
    case (state_r)
      ST_ABSORB: begin
        if (item_valid && room) begin
          item_pop = 1'b1;
          if (item.has_byte) begin
            shift_en   = 1'b1;
            shift_byte = item.data_byte;
            add_bits   = 1'b1;
          end
          if (item.end_of_message) state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        if (room) begin
          shift_en   = 1'b1;
          shift_byte = PAD_MARK;
          state_nxt  = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_r == LEN_FIELD_POS) begin
          len_idx_nxt = '0;
          state_nxt   = ST_LEN;
        end else if (room) begin
          shift_en = 1'b1;
        end
      end
      ST_LEN: begin
        if (room) begin
          shift_en    = 1'b1;
          shift_byte  = len64[{~len_idx_r, 3'b000} +: 8];
          len_idx_nxt = len_idx_r + 1'b1;
          if (len_idx_r == LAST_LEN_BYTE) state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (cmp_ctrl.start) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) begin
          word_cnt_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out     = 1'b1;
          word_cnt_nxt = word_cnt_r + 1'b1;
          if (word_cnt_r == LAST_WORD_IDX) begin
            cmp_ctrl.init = 1'b1;
            clr_bits      = 1'b1;
            state_nxt     = ST_ABSORB;
          end
        end
      end
      default: state_nxt = ST_ABSORB;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ABSORB;
      fill_r      <= '0;
      bit_count_r <= '0;
      len_idx_r   <= '0;
      word_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      len_idx_r  <= len_idx_nxt;
      word_cnt_r <= word_cnt_nxt;
      if (cmp_ctrl.start) fill_r <= '0;
      else if (shift_en)  fill_r <= fill_r + 1'b1;
      if (clr_bits)      bit_count_r <= '0;
      else if (add_bits) bit_count_r <= bit_count_r + BYTE_BITS;
    end
  end

  // Block buffer: bytes shift in, first byte ends up on top
  always_ff @(posedge clk) begin
    if (shift_en) buf_r <= {buf_r[503:0], shift_byte};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r <= chain[word_cnt_r];
      out_idx_r  <= word_cnt_r;
      out_last_r <= (word_cnt_r == LAST_WORD_IDX);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule

// ===== rtl/sha1_byte_stream_hasher_core.sv =====
// Message bytes enter a 4-deep request queue and are absorbed one per cycle while the block buffer has room.
// A block compression (start, 80 rounds, chain add) overlaps with filling the next block.
// After the end request leaves the queue, padding and the final compression precede the first
// digest word, which comes later while an earlier compression is running; the five words
// follow back to back unless stalled.
// Synchronous active-low reset restores the initial chaining words and clears counts.
module sha1_byte_stream_hasher_core #(
  parameter int unsigned LENGTH_BITS = sha1bh_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1bh_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // Front: accept and queue requests
  sha1bh_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .item_valid        (item_valid),
    .item              (item),
    .item_pop          (item_pop)
  );

  // Back: buffer, padding, compression, digest output
  sha1bh_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ===== tb/tb_sha1_byte_stream_hasher_core.sv =====
`timescale 1ns / 100ps

module tb_sha1_byte_stream_hasher_core;
  import sha1bh_pkg::*;

  localparam int unsigned RAND_ITEMS      = 440;
  localparam int unsigned RX_HOLD_CYCLES  = 600;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = 400;
  localparam int unsigned MAX_MSG_PRINTS  = 20;

  // One digest word as the block should emit it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // SHA-1 predictor plus queue of digest words still owed by the block
  class digest_scoreboard;
    logic [31:0]  chain [5];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  bits_seen;
    digest_word_t words_due [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = IV0;
      chain[1] = IV1;
      chain[2] = IV2;
      chain[3] = IV3;
      chain[4] = IV4;
      fill = 0;
      bits_seen = '0;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_MSG_PRINTS)
        $display("[%0t] digest mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // 80-round compression of blk into chain
    function void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int i;
      for (i = 0; i < 16; i++)
        sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (i = 16; i < 80; i++) begin
        x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
        sched[i] = {x[30:0], x[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Pad, compress the tail, queue the five words, start a fresh message
    function void finish_message();
      logic [63:0] len_bits;
      digest_word_t dw;
      int unsigned pos;
      int i;
      len_bits = bits_seen & ({64{1'b1}} >> (64 - LENGTH_BITS_DEF));
      pos = fill;
      blk[pos] = PAD_MARK;
      pos++;
      // mark landed past the length field: extra block
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = PAD_ZERO;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = PAD_ZERO;
        pos++;
      end
      for (i = 0; i < 8; i++)
        blk[56+i] = len_bits[63-8*i -: 8];
      compress_block();
      for (i = 0; i < 5; i++) begin
        dw.word = chain[i];
        dw.idx  = 3'(i);
        dw.last = (3'(i) == LAST_WORD_IDX);
        words_due.push_back(dw);
      end
      restart();
    endfunction

    // Accepted input request
    function void take_request(logic [7:0] data, logic has, logic eom);
      if (has) begin
        blk[fill] = data;
        fill++;
        bits_seen = (bits_seen + 64'd8) & ({64{1'b1}} >> (64 - LENGTH_BITS_DEF));
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
      end
      if (eom)
        finish_message();
    endfunction

    // Accepted output word against the oldest expectation
    task check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t dw;
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h idx %0d", word, idx));
        return;
      end
      dw = words_due.pop_front();
      if (word !== dw.word)
        report_mismatch($sformatf("word idx %0d got %08h want %08h", dw.idx, word, dw.word));
      if (idx !== dw.idx)
        report_mismatch($sformatf("word_index got %0d want %0d", idx, dw.idx));
      if (last !== dw.last)
        report_mismatch($sformatf("last_word idx %0d got %b want %b", dw.idx, last, dw.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb;
  bit          in_take_seen = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned items_sent = 0;

  sha1_byte_stream_hasher_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always #10 clk = ~clk;

  // Sample both handshakes mid-cycle; they complete at the next rising edge
  always @(negedge clk) begin
    in_take_seen = rst_n && in_valid && !in_stall;
    if (in_take_seen)
      sb.take_request(in_data_byte, in_has_byte, in_end_of_message);
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_digest_word, out_word_index, out_last_word);
  end

  // Result side: random stalls, quiet stretches, and one long hold on request
  initial begin
    bit hold;
    int unsigned span;
    int unsigned r;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = 1'b1;
        span = RX_HOLD_CYCLES;
      end else if (r < 30) begin
        hold = 1'b0;
        span = $urandom_range(40, 150);
      end else if (r < 70) begin
        hold = 1'b0;
        span = $urandom_range(1, 4);
      end else if (r < 93) begin
        hold = 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        hold = 1'b1;
        span = $urandom_range(15, 60);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  // Cycles with no request moving on either side
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle = 0;
      else
        idle++;
    end
    $display("tb_sha1_byte_stream_hasher_core: FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    else if (r < 93)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // Lengths: mostly short, some around the padding boundaries, a few long
  function automatic int unsigned pick_message_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return $urandom_range(0, 12);
    else if (r < 82) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 62;
        4: return 63;
        5: return 64;
        6: return 119;
        default: return 120;
      endcase
    end else
      return $urandom_range(0, 130);
  endfunction

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_request(input logic [7:0] data, input logic has, input logic eom,
                              input bit no_gaps);
    int unsigned gap;
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_take_seen)
      @(posedge clk);
    if (has || eom)
      items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random message; end marker rides on the last byte or comes alone
  task automatic send_message(input int unsigned len, input bit end_alone, input bit no_gaps);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, no_gaps);
      send_request(8'($urandom_range(0, 255)), 1'b1,
                   (i == len - 1) && !end_alone, no_gaps);
    end
    if (end_alone || len == 0)
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, no_gaps);
  endtask

  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then an ignored request
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0, 1'b0);
    // "abc" with the end marker on the last byte
    send_request(8'h61, 1'b1, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0, 1'b1);
    send_request(8'h63, 1'b1, 1'b1, 1'b1);
    // single-byte extremes
    send_request(8'hFF, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    // end without a byte after some bytes; data is ignored
    send_request(8'h80, 1'b1, 1'b0, 1'b0);
    send_request(8'h7F, 1'b1, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b1, 1'b0);
    // back to back empties
    send_request(8'hFF, 1'b0, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1, 1'b0);

    while (items_sent < RAND_ITEMS) begin
      // result side held off while requests keep coming: block backs up
      if (!pressure_done && items_sent >= RAND_ITEMS / 2) begin
        rx_hold_req = 1'b1;
        repeat (4) send_message($urandom_range(0, 10), 1'($urandom_range(0, 1)), 1'b1);
        pressure_done = 1'b1;
      end
      send_message(pick_message_len(), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (sb.words_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.words_due.size() == 0)
      $display("tb_sha1_byte_stream_hasher_core: PASS");
    else
      $display("tb_sha1_byte_stream_hasher_core: FAIL");
    $finish;
  end

endmodule
